@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed");
// Next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed");
`endif

@@ hdl/pfe_pkg.sv @@
// Shared types and character codes for the postfix evaluator
`timescale 1ns / 1ps
package pfe_pkg;
  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_item_t;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIV0  = 2'd3;

  // Command kinds handed from front to back
  typedef enum logic [2:0] {
    CMD_NONE, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV
  } op_t;

  typedef struct packed {
    logic       push_num;
    logic [63:0] num;
    op_t        op;
    logic       fin;
  } cmd_t;
endpackage

@@ hdl/pfe_front.sv @@
// Front end: digit accumulation and character classification
`timescale 1ns / 1ps
module pfe_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  pfe_pkg::in_item_t in_item,
  input  logic              in_valid,
  output logic              in_ready,
  output pfe_pkg::cmd_t     cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready
);
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic                   in_num, in_num_next;
  logic [VALUE_WIDTH+3:0] prod;
  logic                   is_digit;
  pfe_pkg::op_t           op;

  assign is_digit = in_item.symbol >= pfe_pkg::CH_0 && in_item.symbol <= pfe_pkg::CH_9;
  assign prod = {4'd0, acc} * 4'd10 + {{VALUE_WIDTH{1'b0}}, in_item.symbol[3:0]};
  assign in_ready = !cmd_valid || cmd_ready;

  // Operator decode
  always_comb begin
    unique case (in_item.symbol)
      pfe_pkg::CH_PLUS:  op = pfe_pkg::CMD_ADD;
      pfe_pkg::CH_MINUS: op = pfe_pkg::CMD_SUB;
      pfe_pkg::CH_STAR:  op = pfe_pkg::CMD_MUL;
      pfe_pkg::CH_SLASH: op = pfe_pkg::CMD_DIV;
      default:           op = pfe_pkg::CMD_NONE;
    endcase
  end

  always_comb begin
    acc_next = acc;
    in_num_next = in_num;
    if (is_digit) begin
      acc_next = prod[VALUE_WIDTH-1:0];
      in_num_next = 1'b1;
    end else begin
      acc_next = '0;
      in_num_next = 1'b0;
    end
    if (in_item.last) begin
      acc_next = '0;
      in_num_next = 1'b0;
    end
  end

  // Command register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      in_num <= 1'b0;
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= 1'b0;
      if (in_valid) begin
        acc <= acc_next;
        in_num <= in_num_next;
        cmd_valid <= (!is_digit && (in_num || op != pfe_pkg::CMD_NONE)) || in_item.last;
        cmd.push_num <= (is_digit ? in_item.last : in_num);
        cmd.num <= 64'(is_digit ? prod[VALUE_WIDTH-1:0] : acc);
        cmd.op <= is_digit ? pfe_pkg::CMD_NONE : op;
        cmd.fin <= in_item.last;
      end
    end
  end
endmodule

@@ hdl/pfe_back.sv @@
// Back end: operand stack, arithmetic and serial divider
`timescale 1ns / 1ps
module pfe_back #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  pfe_pkg::cmd_t      cmd,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  output pfe_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = $clog2(VALUE_WIDTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_PUSH, S_RD1, S_RD2, S_ALU, S_DIV, S_WB, S_FIN
  } state_t;

  state_t state;
  logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] rd, lhs, rhs, res, rem, quo;
  logic [CW-1:0] cnt;
  logic [AW-1:0] raddr;
  logic [1:0]    err;
  pfe_pkg::cmd_t cur;
  logic [DW-1:0] dcnt;
  logic          neg_q;
  logic [VALUE_WIDTH:0] trial;
  logic [2*VALUE_WIDTH-1:0] mprod;

  assign cmd_ready = state == S_IDLE && !out_valid;
  assign trial = {rem, quo[VALUE_WIDTH-1]} - {1'b0, rhs};
  assign mprod = lhs * rhs;

  // Stack memory read
  always_ff @(posedge clk) rd <= mem[raddr];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      err <= pfe_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd_valid && cmd_ready) begin
          cur <= cmd;
          state <= cmd.push_num ? S_PUSH : S_RD1;
        end
        S_PUSH: begin
          if (err == pfe_pkg::ST_OK) begin
            if (cnt == DEPTH_C) err <= pfe_pkg::ST_OVER;
            else begin
              mem[cnt[AW-1:0]] <= cur.num[VALUE_WIDTH-1:0];
              cnt <= cnt + 1'b1;
            end
          end
          state <= S_RD1;
        end
        S_RD1: begin
          raddr <= AW'(cnt - 1'b1);
          if (cur.op == pfe_pkg::CMD_NONE) state <= cur.fin ? S_WB : S_IDLE;
          else if (err != pfe_pkg::ST_OK) state <= cur.fin ? S_FIN : S_IDLE;
          else if (cnt < CW'(2)) begin
            err <= pfe_pkg::ST_UNDER;
            state <= cur.fin ? S_FIN : S_IDLE;
          end else state <= S_RD2;
        end
        S_RD2: begin
          raddr <= AW'(cnt - CW'(2));
          state <= S_ALU;
        end
        S_ALU: begin
          // rd holds right operand now; left arrives next cycle
          rhs <= rd;
          state <= S_DIV;
          dcnt <= '0;
        end
        S_DIV: begin
          if (dcnt == '0) begin
            lhs <= rd;
            dcnt <= DW'(1);
            rem <= '0;
            neg_q <= rd[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1];
            quo <= rd[VALUE_WIDTH-1] ? -rd : rd;
            if (cur.op == pfe_pkg::CMD_DIV) begin
              if (rhs == '0) begin
                err <= pfe_pkg::ST_DIV0;
                state <= cur.fin ? S_FIN : S_IDLE;
              end else if (rhs[VALUE_WIDTH-1]) rhs <= -rhs;
            end
          end else if (cur.op != pfe_pkg::CMD_DIV) begin
            unique case (cur.op)
              pfe_pkg::CMD_ADD: res <= lhs + rhs;
              pfe_pkg::CMD_SUB: res <= lhs - rhs;
              default:          res <= mprod[VALUE_WIDTH-1:0];
            endcase
            state <= S_WB;
            dcnt <= '0;
          end else if (dcnt == DW'(VALUE_WIDTH + 1)) begin
            res <= neg_q ? -quo : quo;
            state <= S_WB;
            dcnt <= '0;
          end else begin
            // One quotient bit per cycle, restoring
            if (!trial[VALUE_WIDTH]) rem <= trial[VALUE_WIDTH-1:0];
            else rem <= {rem[VALUE_WIDTH-2:0], quo[VALUE_WIDTH-1]};
            quo <= {quo[VALUE_WIDTH-2:0], !trial[VALUE_WIDTH]};
            dcnt <= dcnt + 1'b1;
          end
        end
        S_WB: begin
          if (cur.op != pfe_pkg::CMD_NONE) begin
            mem[AW'(cnt - CW'(2))] <= res;
            cnt <= cnt - 1'b1;
            raddr <= AW'(cnt - CW'(2));
          end
          state <= cur.fin ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
          cnt <= '0;
          err <= pfe_pkg::ST_OK;
          out_item.value <= '0;
          if (err != pfe_pkg::ST_OK) out_item.status <= err;
          else if (cnt == '0) out_item.status <= pfe_pkg::ST_UNDER;
          else begin
            out_item.status <= pfe_pkg::ST_OK;
            out_item.value <= 32'(signed'(cur.op != pfe_pkg::CMD_NONE ? res : rd));
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/postfix_expression_evaluator.sv @@
// Top level of the postfix expression evaluator
// Channel | Direction | Handshake
// in      | input     | push / full
// out     | output    | pop / empty
// A digit is accumulated in the front; a bare push takes the back through S_PUSH
// and S_RD1, an add, subtract or multiply through S_RD1, S_RD2, S_ALU, S_DIV and
// S_WB, after S_PUSH with a pending number. Division iterates one quotient bit a
// cycle in S_DIV. The final character adds S_FIN to load the result register.
// One-entry command register between front and back; the back accepts no
// command while a result waits. Reset: rst synchronous, clears stack count,
// accumulator and error.
`timescale 1ns / 1ps
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  pfe_pkg::in_item_t  in_item,
  input  logic               push,
  output logic               full,
  output pfe_pkg::out_item_t out_item,
  output logic               empty,
  input  logic               pop
);
  pfe_pkg::cmd_t cmd;
  logic cmd_valid, cmd_ready, in_ready, out_valid;

  assign full = !in_ready;
  assign empty = !out_valid;

  pfe_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk, .rst, .in_item, .in_valid(push), .in_ready,
    .cmd, .cmd_valid, .cmd_ready
  );
  pfe_back #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_ready,
    .out_item, .out_valid, .out_ready(pop)
  );
endmodule

@@ hdl/pfe_checker.sv @@
// Port-level checks for the postfix evaluator
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pfe_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input pfe_pkg::out_item_t out_item
);
  `CHK_IMPLY(err_zero_value, clk, rst, !empty && out_item.status != pfe_pkg::ST_OK, out_item.value == 0)
  `CHK_NEXT(res_held, clk, rst, !empty && !pop, !empty && $stable(out_item))
  `CHK_NEXT(res_gone, clk, rst, !empty && pop, empty)
  `CHK_IMPLY(idle_after_reset, clk, rst, $past(rst), empty && !full)
endmodule

bind postfix_expression_evaluator pfe_checker u_chk (
  .clk, .rst, .full, .empty, .pop, .out_item
);
